// ===== rtl/core/pqc_pkg.sv =====
`timescale 1ns / 1ps

package pqc_pkg;

    // width of the saturating pulse accumulator
    localparam int COUNT_WIDTH = 16;
    localparam int OUT_COUNT_WIDTH = 16;
    localparam int TIME_WIDTH = 32;
    localparam int CFG_INDEX_WIDTH = 3;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // configuration register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_FILTER_MODE = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_EDGE_LOCKOUT = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_COALESCE_WINDOW = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MIN_LOW = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MIN_HIGH = 3'd4;

    // filter modes
    localparam logic MODE_EDGE = 1'b0;
    localparam logic MODE_PULSE = 1'b1;

    // item operations
    localparam logic OP_PIN_EVENT = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef struct packed {
        logic                  filter_mode;
        logic [TIME_WIDTH-1:0] edge_lockout_us;
        logic [TIME_WIDTH-1:0] coalesce_window_us;
        logic [TIME_WIDTH-1:0] min_low_us;
        logic [TIME_WIDTH-1:0] min_high_us;
    } cfg_t;

    typedef struct packed {
        logic                  operation;
        logic [TIME_WIDTH-1:0] time_us;
        logic                  pin_level;
    } item_t;

    typedef struct packed {
        logic                       pulse_accepted;
        logic [OUT_COUNT_WIDTH-1:0] pulse_count;
        logic [TIME_WIDTH-1:0]      last_detected_us;
        logic [TIME_WIDTH-1:0]      last_rising_us;
        logic                       event_seen;
    } result_t;

endpackage

// ===== rtl/core/pqc_core.sv =====
`timescale 1ns / 1ps

module pqc_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step_en,
    input  pqc_pkg::item_t  item,
    input  pqc_pkg::cfg_t   cfg,
    output pqc_pkg::result_t result
);

    localparam int TW = pqc_pkg::TIME_WIDTH;
    localparam int CW = pqc_pkg::COUNT_WIDTH;
    localparam int OW = pqc_pkg::OUT_COUNT_WIDTH;

    // qualifier state
    logic          latched_high_reg;
    logic          previous_level_reg;
    logic [TW-1:0] last_change_time_reg;
    logic [TW-1:0] last_edge_time_reg;
    logic [TW-1:0] coalesce_until_reg;
    logic [CW-1:0] pending_count_reg;
    logic [TW-1:0] detected_time_reg;
    logic [TW-1:0] rising_time_reg;
    logic          event_flag_reg;

    logic          latched_high_next;
    logic [TW-1:0] last_edge_time_next;
    logic [TW-1:0] coalesce_until_next;
    logic [CW-1:0] pending_count_next;
    logic [TW-1:0] detected_time_next;
    logic [TW-1:0] rising_time_next;
    logic          event_flag_next;

    logic          pin_event;
    logic          coalesce_on;
    logic [TW-1:0] coalesce_diff;
    logic [TW-1:0] edge_elapsed;
    logic          edge_ok;
    logic [TW-1:0] held;
    logic          latch_release;
    logic          latch_set;
    logic          accepted;
    logic [CW+OW-1:0] count_wide;

    // edge mode checks: coalescing window and lockout since last accepted edge
    assign pin_event     = (item.operation == pqc_pkg::OP_PIN_EVENT);
    assign coalesce_on   = (cfg.coalesce_window_us != '0);
    assign coalesce_diff = item.time_us - coalesce_until_reg;
    assign edge_elapsed  = item.time_us - last_edge_time_reg;
    assign edge_ok       = !(coalesce_on && coalesce_diff[TW-1])
                           && !(edge_elapsed < cfg.edge_lockout_us);

    // pulse mode hysteresis on the held level
    assign held          = item.time_us - last_change_time_reg;
    assign latch_release = latched_high_reg && !previous_level_reg
                           && (held >= cfg.min_low_us);
    assign latch_set     = !latched_high_reg && previous_level_reg
                           && (held >= cfg.min_high_us);

    // next state for a pin event, and the values shown in the result
    always_comb
    begin
        latched_high_next   = latched_high_reg;
        last_edge_time_next = last_edge_time_reg;
        coalesce_until_next = coalesce_until_reg;
        detected_time_next  = detected_time_reg;
        rising_time_next    = rising_time_reg;
        accepted            = 1'b0;
        if (pin_event)
        begin
            if (cfg.filter_mode == pqc_pkg::MODE_EDGE)
            begin
                if (edge_ok)
                begin
                    accepted            = 1'b1;
                    last_edge_time_next = item.time_us;
                    detected_time_next  = item.time_us;
                    rising_time_next    = item.time_us;
                    if (coalesce_on)
                    begin
                        coalesce_until_next = item.time_us + cfg.coalesce_window_us;
                    end
                end
            end
            else
            begin
                if (latch_set)
                begin
                    latched_high_next  = 1'b1;
                    detected_time_next = last_change_time_reg;
                    accepted           = 1'b1;
                end
                else if (latch_release)
                begin
                    latched_high_next = 1'b0;
                end
                rising_time_next = (!latched_high_next && item.pin_level)
                                   ? item.time_us : detected_time_next;
            end
        end
        pending_count_next = pending_count_reg;
        if (accepted && (pending_count_reg != pqc_pkg::COUNT_MAX))
        begin
            pending_count_next = pending_count_reg + CW'(1);
        end
        event_flag_next = event_flag_reg || accepted;
    end

    // low bits of the accumulator, zero extended when it is narrow
    assign count_wide = {{OW{1'b0}}, pending_count_next};

    assign result.pulse_accepted   = accepted;
    assign result.pulse_count      = count_wide[OW-1:0];
    assign result.last_detected_us = detected_time_next;
    assign result.last_rising_us   = rising_time_next;
    assign result.event_seen       = event_flag_next;

    // state update, read clears count and flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latched_high_reg     <= 1'b0;
            previous_level_reg   <= 1'b0;
            last_change_time_reg <= '0;
            last_edge_time_reg   <= '0;
            coalesce_until_reg   <= '0;
            pending_count_reg    <= '0;
            detected_time_reg    <= '0;
            rising_time_reg      <= '0;
            event_flag_reg       <= 1'b0;
        end
        else if (step_en)
        begin
            if (pin_event)
            begin
                latched_high_reg   <= latched_high_next;
                last_edge_time_reg <= last_edge_time_next;
                coalesce_until_reg <= coalesce_until_next;
                detected_time_reg  <= detected_time_next;
                rising_time_reg    <= rising_time_next;
                pending_count_reg  <= pending_count_next;
                event_flag_reg     <= event_flag_next;
                if (cfg.filter_mode == pqc_pkg::MODE_PULSE)
                begin
                    last_change_time_reg <= item.time_us;
                    previous_level_reg   <= item.pin_level;
                end
            end
            else
            begin
                pending_count_reg <= '0;
                event_flag_reg    <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/core/pulse_qualifier_counter_unit.sv =====
`timescale 1ns / 1ps

// Pulse qualifier and counter. Each input beat is either a timestamped pin
// event or a read; every beat yields exactly one result beat. The unit takes
// one beat per clock while the output register is free: a beat is captured in
// an input register, and the qualifier state is updated when the result is
// written to the output register, where it is held until it is taken.
// The beat rate is set by the state update loop in the qualifier.
// Configuration writes are accepted in every cycle and must only be issued
// while no beat is in flight.
module pulse_qualifier_counter_unit (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic        operation,
    input  logic [31:0] time_us,
    input  logic        pin_level,

    output logic        out_valid,
    input  logic        out_ready,
    output logic        pulse_accepted,
    output logic [15:0] pulse_count,
    output logic [31:0] last_detected_us,
    output logic [31:0] last_rising_us,
    output logic        event_seen
);

    pqc_pkg::cfg_t    cfg_reg;
    pqc_pkg::item_t   item_reg;
    pqc_pkg::result_t result;
    pqc_pkg::result_t result_reg;
    logic             item_valid_reg;
    logic             out_valid_reg;
    logic             out_free;
    logic             step_en;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                pqc_pkg::REG_FILTER_MODE:     cfg_reg.filter_mode        <= cfg_data[0];
                pqc_pkg::REG_EDGE_LOCKOUT:    cfg_reg.edge_lockout_us    <= cfg_data;
                pqc_pkg::REG_COALESCE_WINDOW: cfg_reg.coalesce_window_us <= cfg_data;
                pqc_pkg::REG_MIN_LOW:         cfg_reg.min_low_us         <= cfg_data;
                pqc_pkg::REG_MIN_HIGH:        cfg_reg.min_high_us        <= cfg_data;
                default:                      cfg_reg                    <= cfg_reg;
            endcase
        end
    end

    // pipeline flow control
    assign out_free = !out_valid_reg || out_ready;
    assign step_en  = item_valid_reg && out_free;
    assign in_ready = !item_valid_reg || out_free;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            item_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.operation <= operation;
            item_reg.time_us   <= time_us;
            item_reg.pin_level <= pin_level;
        end
    end

    pqc_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step_en(step_en),
        .item   (item_reg),
        .cfg    (cfg_reg),
        .result (result)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= item_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            result_reg <= result;
        end
    end

    assign out_valid        = out_valid_reg;
    assign pulse_accepted   = result_reg.pulse_accepted;
    assign pulse_count      = result_reg.pulse_count;
    assign last_detected_us = result_reg.last_detected_us;
    assign last_rising_us   = result_reg.last_rising_us;
    assign event_seen       = result_reg.event_seen;

    // a counted pulse always marks the event flag
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pulse_accepted |-> event_seen)
        else $error("counted pulse without event flag");

    // a counted pulse leaves no pending rise apart from the detected one
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pulse_accepted |-> last_rising_us == last_detected_us)
        else $error("rising time differs from detected time on a counted pulse");

    // a nonzero count can only come from counted pulses since the last read
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (pulse_count != '0) |-> event_seen)
        else $error("nonzero count without event flag");

    // an accepted beat is held in the input register in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> item_valid_reg)
        else $error("accepted beat lost from input register");

endmodule

// ===== tb/sv/pulse_qualifier_counter_unit_test.sv =====
`timescale 1ns / 1ps

module pulse_qualifier_counter_unit_test;

    import pqc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 4;
    localparam int RANDOM_PHASES = 14;
    localparam int PHASE_BEATS = 130;
    localparam int CALM_PHASES = 3;
    localparam int BURST_BEATS = 40;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_FIRST = REG_MIN_HIGH + 3'd1;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        operation = OP_PIN_EVENT;
    logic [31:0] time_us = '0;
    logic        pin_level = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b1;
    logic        pulse_accepted;
    logic [15:0] pulse_count;
    logic [31:0] last_detected_us;
    logic [31:0] last_rising_us;
    logic        event_seen;

    pulse_qualifier_counter_unit dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .operation        (operation),
        .time_us          (time_us),
        .pin_level        (pin_level),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .pulse_accepted   (pulse_accepted),
        .pulse_count      (pulse_count),
        .last_detected_us (last_detected_us),
        .last_rising_us   (last_rising_us),
        .event_seen       (event_seen)
    );

    // shadow configuration
    logic                   mode_q = MODE_EDGE;
    logic [TIME_WIDTH-1:0]  lockout_q = '0;
    logic [TIME_WIDTH-1:0]  window_q = '0;
    logic [TIME_WIDTH-1:0]  min_low_q = '0;
    logic [TIME_WIDTH-1:0]  min_high_q = '0;

    // shadow qualifier state
    logic                   latched = 1'b0;
    logic                   prev_lvl = 1'b0;
    logic [TIME_WIDTH-1:0]  change_t = '0;
    logic [TIME_WIDTH-1:0]  edge_t = '0;
    logic [TIME_WIDTH-1:0]  window_end = '0;
    logic [COUNT_WIDTH-1:0] pulse_tally = '0;
    logic [TIME_WIDTH-1:0]  det_t = '0;
    logic [TIME_WIDTH-1:0]  rise_t = '0;
    logic                   seen = 1'b0;

    result_t predicted_reports[$];

    int  errors = 0;
    int  cycle_count = 0;
    int  beats_sent = 0;
    int  reads_sent = 0;
    int  pulses_seen = 0;
    int  stall_left = 0;
    bit  idle_on = 1'b1;
    logic [31:0] stamp_now = '0;

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // cycle limit
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("pulse_qualifier_counter_unit_test: done, errors");
        $finish;
    end

    // receiver back-pressure in random bursts
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 9);
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // wrapping "a is before b"
    function automatic logic earlier(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return d[31];
    endfunction

    function automatic void bump_tally();
        if (pulse_tally != COUNT_MAX)
            pulse_tally = pulse_tally + COUNT_WIDTH'(1);
        seen = 1'b1;
    endfunction

    // expected report for one accepted beat, then state update
    function automatic void qualify_beat(input logic op, input logic [31:0] now,
                                         input logic lvl);
        result_t r;
        logic hit;
        logic [31:0] since;
        hit = 1'b0;
        if (op == OP_PIN_EVENT)
        begin
            if (mode_q == MODE_EDGE)
            begin
                since = now - edge_t;
                if (!(window_q != 0 && earlier(now, window_end)) && since >= lockout_q)
                begin
                    edge_t = now;
                    det_t = now;
                    rise_t = now;
                    bump_tally();
                    if (window_q != 0)
                        window_end = now + window_q;
                    hit = 1'b1;
                end
            end
            else
            begin
                since = now - change_t;
                if (latched && !prev_lvl)
                begin
                    if (since >= min_low_q)
                        latched = 1'b0;
                end
                else if (!latched && prev_lvl)
                begin
                    if (since >= min_high_q)
                    begin
                        latched = 1'b1;
                        det_t = change_t;
                        bump_tally();
                        hit = 1'b1;
                    end
                end
                rise_t = (!latched && lvl) ? now : det_t;
                change_t = now;
                prev_lvl = lvl;
            end
        end
        r.pulse_accepted = hit;
        r.pulse_count = pulse_tally[OUT_COUNT_WIDTH-1:0];
        r.last_detected_us = det_t;
        r.last_rising_us = rise_t;
        r.event_seen = seen;
        predicted_reports.push_back(r);
        if (op == OP_READ)
        begin
            pulse_tally = '0;
            seen = 1'b0;
        end
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            errors++;
        end
    endfunction

    // result checker
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (predicted_reports.size() == 0)
            begin
                $display("%0t: result beat with nothing expected", $time);
                errors++;
            end
            else
            begin
                want = predicted_reports.pop_front();
                check_field("pulse_accepted", 32'(want.pulse_accepted),
                            32'(pulse_accepted));
                check_field("pulse_count", 32'(want.pulse_count), 32'(pulse_count));
                check_field("last_detected_us", want.last_detected_us, last_detected_us);
                check_field("last_rising_us", want.last_rising_us, last_rising_us);
                check_field("event_seen", 32'(want.event_seen), 32'(event_seen));
                if (pulse_accepted)
                    pulses_seen++;
            end
        end
    end

    // send one beat, with an optional idle burst first
    task automatic push_beat(input logic op, input logic [31:0] t, input logic lvl);
        int gap;
        cfg_valid <= 1'b0;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 10);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        time_us <= t;
        pin_level <= lvl;
        do @(posedge clk); while (!in_ready);
        qualify_beat(op, t, lvl);
        beats_sent++;
        if (op == OP_READ)
            reads_sent++;
    endtask

    // quiet the inputs and wait for every expected result
    task automatic settle();
        in_valid <= 1'b0;
        cfg_valid <= 1'b0;
        while (predicted_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // register write; caller has settled the unit
    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_FILTER_MODE:     mode_q = val[0];
            REG_EDGE_LOCKOUT:    lockout_q = val;
            REG_COALESCE_WINDOW: window_q = val;
            REG_MIN_LOW:         min_low_q = val;
            REG_MIN_HIGH:        min_high_q = val;
            default:             ;
        endcase
    endtask

    task automatic test_reset_state();
        push_beat(OP_READ, 32'hFFFFFFFF, 1'b1);
        push_beat(OP_PIN_EVENT, 32'h0, 1'b0);
        push_beat(OP_READ, 32'h0, 1'b0);
        // writes to unused indexes change nothing
        settle();
        for (int i = REG_SPARE_FIRST; i < 8; i++)
            write_reg(i[CFG_INDEX_WIDTH-1:0], $urandom);
        push_beat(OP_PIN_EVENT, 32'h7, 1'b1);
    endtask

    task automatic test_edge_lockout();
        settle();
        write_reg(REG_EDGE_LOCKOUT, 32'd100);
        push_beat(OP_PIN_EVENT, 32'd1000, 1'b1);
        push_beat(OP_PIN_EVENT, 32'd1050, 1'b0);
        push_beat(OP_PIN_EVENT, 32'd1100, 1'b1);
        // lockout measured across the timestamp wrap
        push_beat(OP_PIN_EVENT, 32'hFFFFFFF0, 1'b1);
        push_beat(OP_PIN_EVENT, 32'h50, 1'b0);
        push_beat(OP_PIN_EVENT, 32'h54, 1'b1);
        settle();
        write_reg(REG_EDGE_LOCKOUT, 32'hFFFFFFFF);
        push_beat(OP_PIN_EVENT, 32'h53, 1'b0);
        push_beat(OP_READ, 32'h0, 1'b0);
    endtask

    task automatic test_coalesce();
        settle();
        write_reg(REG_EDGE_LOCKOUT, 32'd0);
        write_reg(REG_COALESCE_WINDOW, 32'd500);
        push_beat(OP_PIN_EVENT, 32'd2000, 1'b1);
        push_beat(OP_PIN_EVENT, 32'd2499, 1'b1);
        push_beat(OP_PIN_EVENT, 32'd2500, 1'b0);
        settle();
        write_reg(REG_COALESCE_WINDOW, 32'hFFFFFFFF);
        push_beat(OP_PIN_EVENT, 32'd3000, 1'b1);
        push_beat(OP_PIN_EVENT, 32'd3001, 1'b1);
        push_beat(OP_READ, 32'd0, 1'b1);
    endtask

    task automatic test_hysteresis();
        settle();
        write_reg(REG_FILTER_MODE, {31'h0, MODE_PULSE});
        write_reg(REG_MIN_LOW, 32'd10);
        write_reg(REG_MIN_HIGH, 32'd20);
        push_beat(OP_PIN_EVENT, 32'd100, 1'b1);
        push_beat(OP_PIN_EVENT, 32'd115, 1'b0);
        push_beat(OP_PIN_EVENT, 32'd200, 1'b1);
        push_beat(OP_PIN_EVENT, 32'd230, 1'b0);
        push_beat(OP_PIN_EVENT, 32'd235, 1'b1);
        push_beat(OP_PIN_EVENT, 32'd240, 1'b0);
        push_beat(OP_PIN_EVENT, 32'd260, 1'b1);
        push_beat(OP_READ, 32'd0, 1'b0);
        // widest hold times: only a full wrap qualifies
        settle();
        write_reg(REG_MIN_LOW, 32'hFFFFFFFF);
        write_reg(REG_MIN_HIGH, 32'hFFFFFFFF);
        push_beat(OP_PIN_EVENT, 32'd259, 1'b0);
        push_beat(OP_PIN_EVENT, 32'd300, 1'b1);
    endtask

    task automatic test_mode_switch();
        settle();
        write_reg(REG_MIN_LOW, 32'd0);
        write_reg(REG_MIN_HIGH, 32'd0);
        push_beat(OP_PIN_EVENT, 32'd5000, 1'b1);
        push_beat(OP_PIN_EVENT, 32'd5100, 1'b0);
        settle();
        write_reg(REG_FILTER_MODE, {31'h0, MODE_EDGE});
        push_beat(OP_PIN_EVENT, 32'd5200, 1'b1);
        settle();
        write_reg(REG_FILTER_MODE, {31'h0, MODE_PULSE});
        push_beat(OP_PIN_EVENT, 32'd5300, 1'b1);
        push_beat(OP_READ, 32'd0, 1'b0);
    endtask

    // back to back counted pulses with no idling on either side
    task automatic test_pulse_burst();
        bit keep_idle;
        keep_idle = idle_on;
        settle();
        idle_on = 1'b0;
        write_reg(REG_FILTER_MODE, {31'h0, MODE_EDGE});
        write_reg(REG_EDGE_LOCKOUT, 32'd0);
        write_reg(REG_COALESCE_WINDOW, 32'd0);
        push_beat(OP_READ, 32'd0, 1'b0);
        for (int i = 0; i < BURST_BEATS; i++)
            push_beat(OP_PIN_EVENT, 32'd10000 + i, 1'($urandom_range(0, 1)));
        push_beat(OP_READ, 32'd0, 1'b0);
        push_beat(OP_PIN_EVENT, 32'd90000, 1'b1);
        push_beat(OP_READ, 32'd0, 1'b0);
        settle();
        idle_on = keep_idle;
    endtask

    function automatic logic [31:0] pick_threshold();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return 32'hFFFFFFFF;
            2: return $urandom;
            3: return 32'h80000000;
            default: return $urandom_range(1, 60);
        endcase
    endfunction

    // random configuration, then well-formed event trains with some noise
    task automatic test_random_phase(input int beats);
        logic [31:0] scale;
        logic [31:0] step;
        logic        lvl;
        settle();
        write_reg(REG_FILTER_MODE, $urandom);
        write_reg(REG_EDGE_LOCKOUT, pick_threshold());
        write_reg(REG_COALESCE_WINDOW, pick_threshold());
        write_reg(REG_MIN_LOW, pick_threshold());
        write_reg(REG_MIN_HIGH, pick_threshold());
        if (mode_q == MODE_EDGE)
            scale = (lockout_q > window_q) ? lockout_q : window_q;
        else
            scale = (min_low_q > min_high_q) ? min_low_q : min_high_q;
        if (scale > 200)
            scale = $urandom_range(20, 200);
        case ($urandom_range(0, 2))
            0: stamp_now = $urandom;
            1: stamp_now = 32'hFFFFFFFF - $urandom_range(0, 500);
            default: ;
        endcase
        lvl = prev_lvl;
        for (int i = 0; i < beats; i++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                push_beat(OP_READ, $urandom, 1'($urandom_range(0, 1)));
            end
            else
            begin
                case ($urandom_range(0, 15))
                    0: step = $urandom;
                    1: step = 32'd0;
                    default: step = $urandom_range(0, 2 * scale + 4);
                endcase
                stamp_now = stamp_now + step;
                if (mode_q == MODE_PULSE)
                    lvl = ($urandom_range(0, 3) != 0) ? !lvl : lvl;
                else
                    lvl = 1'($urandom_range(0, 1));
                push_beat(OP_PIN_EVENT, stamp_now, lvl);
            end
        end
    endtask

    // stimulus sequence
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_edge_lockout();
        test_coalesce();
        test_hysteresis();
        test_mode_switch();
        test_pulse_burst();
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p >= RANDOM_PHASES - CALM_PHASES)
                idle_on = 1'b0;
            test_random_phase(PHASE_BEATS);
        end
        settle();
        $display("covered %0d beats, %0d of them reads, %0d qualified pulses checked",
                 beats_sent, reads_sent, pulses_seen);
        $display("edge lockout, coalescing, hysteresis, mode switch, wrap, pulse burst, %0d %s",
                 RANDOM_PHASES, "random configuration phases");
        if (errors == 0)
            $display("pulse_qualifier_counter_unit_test: done, clean");
        else
            $display("pulse_qualifier_counter_unit_test: done, errors");
        $finish;
    end

endmodule
